// ----- rtl/suq_pkg.sv -----
// suq_pkg: shared types and codes for the sorted unique priority queue.
// Item structs, status and operation codes, cell control struct.
// No dependencies.
package suq_pkg;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic               func;
        logic signed [31:0] value;
        logic signed [31:0] priority_req;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] out_value;
        logic               now_empty;
        logic [4:0]         entry_count;
    } rsp_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic signed [31:0] prio;
    } entry_t;

    typedef struct packed {
        logic capture;
        logic insert;
        logic remove;
    } cell_ctrl_t;

endpackage

// ----- rtl/suq_cell.sv -----
// suq_cell: one slot of the sorted chain; holds one value/priority pair.
// Compares its priority with the incoming item and shifts left or right.
// Depends on suq_pkg.
module suq_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  suq_pkg::cell_ctrl_t ctrl,
    input  suq_pkg::entry_t     new_entry,
    input  logic [CNT_W-1:0]    count,
    input  suq_pkg::entry_t     left_entry,
    input  logic                left_gt,
    input  suq_pkg::entry_t     right_entry,
    output suq_pkg::entry_t     entry,
    output logic                gt,
    output logic                eq
);
    import suq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   gt_reg;
    logic   eq_reg;
    logic   occupied;

    assign occupied = CNT_W'(IDX) < count;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.insert && !gt_reg)
        begin
            entry_next = left_gt ? new_entry : left_entry;
        end
        else if (ctrl.remove)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gt_reg <= 1'b0;
            eq_reg <= 1'b0;
        end
        else if (ctrl.capture)
        begin
            gt_reg <= occupied && (entry_reg.prio > new_entry.prio);
            eq_reg <= occupied && (entry_reg.prio == new_entry.prio);
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign gt    = gt_reg;
    assign eq    = eq_reg;

endmodule

// ----- rtl/sorted_unique_priority_queue.sv -----
// sorted_unique_priority_queue: top level, control and the chain of cells.
// Depends on suq_pkg and suq_cell.
//
// Usage:
//   An item (func, value, priority_req on req) is taken at a clock edge with
//   start high and busy low. At that edge every cell registers the compare of
//   the item with its priority; then, in the execute state with busy high,
//   the insert or remove shift is applied across the chain. In the next
//   cycle done pulses for one cycle with rsp: status, popped value, empty flag
//   and entry count (count masked to 5 bits). No new item is taken while busy
//   is high, that is before the current item's shift has been applied.
//   A new item may be started while done is high.
//   The receiver cannot stall; done marks each result for one cycle only.
//   Reset empties the queue at once (the count is cleared); slot contents
//   are not cleared and are never observed until written.
module sorted_unique_priority_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  suq_pkg::req_t req,
    output logic          done,
    output suq_pkg::rsp_t rsp
);
    import suq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {S_IDLE, S_EXEC} state_t;

    state_t           state_reg;
    state_t           state_next;
    req_t             req_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             done_reg;
    logic             done_next;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;

    logic             accept;
    logic             dup;
    logic             full;
    logic [31:0]      count_ext;
    cell_ctrl_t       ctrl;
    entry_t           new_entry;
    entry_t           cell_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] cell_gt;
    logic [QUEUE_DEPTH-1:0] cell_eq;

    assign accept = start && (state_reg == S_IDLE);
    assign dup    = |cell_eq;
    assign full   = count_reg == CNT_W'(QUEUE_DEPTH);

    always_comb
    begin
        new_entry.value = accept ? req.value : req_reg.value;
        new_entry.prio  = accept ? req.priority_req : req_reg.priority_req;
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        done_next    = 1'b0;
        rsp_next     = rsp_reg;
        ctrl.capture = accept;
        ctrl.insert  = 1'b0;
        ctrl.remove  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next         = S_IDLE;
                done_next          = 1'b1;
                rsp_next.out_value = '0;
                rsp_next.status    = ST_OK;
                if (req_reg.func == FUNC_PUSH)
                begin
                    if (dup)
                    begin
                        rsp_next.status = ST_DUP;
                    end
                    else if (full)
                    begin
                        rsp_next.status = ST_FULL;
                    end
                    else
                    begin
                        ctrl.insert = 1'b1;
                        count_next  = count_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    if (count_reg == '0)
                    begin
                        rsp_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        ctrl.remove        = 1'b1;
                        rsp_next.out_value = cell_entry[0].value;
                        count_next         = count_reg - CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        count_ext            = 32'(count_next);
        rsp_next.now_empty   = (count_next == '0);
        rsp_next.entry_count = count_ext[4:0];
        if (state_reg != S_EXEC)
        begin
            rsp_next = rsp_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (accept)
        begin
            req_reg <= req;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            entry_t left_e;
            entry_t right_e;
            logic   left_g;
            if (gi == 0)
            begin : g_first
                assign left_e = new_entry;
                assign left_g = 1'b1;
            end
            else
            begin : g_mid
                assign left_e = cell_entry[gi-1];
                assign left_g = cell_gt[gi-1];
            end
            if (gi == QUEUE_DEPTH - 1)
            begin : g_last
                assign right_e = cell_entry[gi];
            end
            else
            begin : g_inner
                assign right_e = cell_entry[gi+1];
            end
            suq_cell #(
                .IDX   (gi),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .new_entry   (new_entry),
                .count       (count_reg),
                .left_entry  (left_e),
                .left_gt     (left_g),
                .right_entry (right_e),
                .entry       (cell_entry[gi]),
                .gt          (cell_gt[gi]),
                .eq          (cell_eq[gi])
            );
        end
    endgenerate

    assign busy = (state_reg == S_EXEC);
    assign done = done_reg;
    assign rsp  = rsp_reg;

`ifndef ASSERT_OFF
    a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("busy held for more than one cycle");

    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done)
        else $error("no result after execute cycle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above depth");

    a_pop_ok_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && ctrl.remove) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("successful pop did not decrement count");
`endif

endmodule
